/* sv/flood_duplicate_table_top_macros.svh */
// Assertion helpers shared by the control and data path modules.
// Both expect clk and rst_n in scope.
`ifndef FLOOD_DUPLICATE_TABLE_TOP_MACROS_SVH
`define FLOOD_DUPLICATE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define FDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fdt_pkg.sv */
package fdt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int ADDR_W              = 32;
    localparam int ID_W                = 32;
    localparam int TIME_W              = 64;
    localparam int REMOVED_W           = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_CLEAR  = 2'd3
    } fdt_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } fdt_status_t;

    typedef struct packed {
        fdt_op_t            opcode;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [ID_W-1:0]    message_id;
        logic [TIME_W-1:0]  expiry_time;
        logic [TIME_W-1:0]  now_time;
    } fdt_req_t;

    typedef struct packed {
        fdt_status_t          status;
        logic [ADDR_W-1:0]    hit_dst_addr;
        logic [TIME_W-1:0]    hit_expiry;
        logic [REMOVED_W-1:0] removed_count;
    } fdt_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } fdt_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic clear;
        logic scan;
    } fdt_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
    } fdt_sts_t;

endpackage

/* sv/fdt_ctrl.sv */
`include "flood_duplicate_table_top_macros.svh"

module fdt_ctrl
    import fdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fdt_op_t  opcode,
    input  fdt_sts_t sts,
    output fdt_ctl_t ctl,
    output logic     busy,
    output logic     done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_CLR,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_INSERT: state_next = S_INS;
                        OP_CLEAR:  state_next = S_CLR;
                        default:   state_next = S_SCAN;
                    endcase
                end
            end
            S_INS, S_CLR:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        ctl.load   = (state_reg == S_IDLE) && start;
        ctl.insert = (state_reg == S_INS);
        ctl.clear  = (state_reg == S_CLR);
        ctl.scan   = (state_reg == S_SCAN);
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `FDT_ASSERT_NXT(a_done_single, done_reg, !done_reg, "result strobe held two cycles")
    `FDT_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "result strobe while busy")
    `FDT_ASSERT_NXT(a_accept_busy, start && !busy_reg, busy_reg, "accepted beat left block idle")

endmodule

/* sv/fdt_datapath.sv */
`include "flood_duplicate_table_top_macros.svh"

module fdt_datapath
    import fdt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  fdt_ctl_t ctl,
    input  fdt_req_t req,
    output fdt_sts_t sts,
    output fdt_rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // physical order: oldest at slot 0, newest at count-1
    fdt_entry_t mem [TABLE_DEPTH];

    fdt_req_t         req_reg;
    fdt_entry_t       rd_data_reg;
    fdt_rsp_t         rsp_reg;
    fdt_rsp_t         rsp_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic [CNT_W-1:0] keep_reg;
    logic [CNT_W-1:0] keep_next;
    logic             rd_vld_reg;

    logic              is_find;
    logic [TIME_W-1:0] diff;
    logic              expired;
    logic              match;
    logic              find_stop;
    logic [CNT_W-1:0]  ptr_dec;
    logic              issue_ok;
    logic              scan_end;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              full;
    logic              ins_wr;
    logic              fl_wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    fdt_entry_t        wr_data;

    always_comb
    begin
        is_find   = (req_reg.opcode == OP_FIND);
        diff      = rd_data_reg.expiry - req_reg.now_time;
        expired   = diff[TIME_W-1];
        match     = (rd_data_reg.src == req_reg.src_addr) &&
                    (rd_data_reg.id == req_reg.message_id);
        find_stop = rd_vld_reg && (expired || match);
        ptr_dec   = ptr_reg - 1'b1;
        // find walks down from the newest slot, flush walks up from slot 0
        issue_ok  = is_find ? (ptr_reg != '0) : (ptr_reg != count_reg);
        scan_end  = is_find ? (find_stop || (!rd_vld_reg && (ptr_reg == '0)))
                            : (!rd_vld_reg && !issue_ok);
        rd_en     = ctl.scan && issue_ok && !(is_find && find_stop);
        rd_addr   = is_find ? ptr_dec[IDX_W-1:0] : ptr_reg[IDX_W-1:0];
        full      = (count_reg == DEPTH_CNT);
        ins_wr    = ctl.insert && !full;
        // flush compaction: keep slot always trails the read pointer
        fl_wr     = ctl.scan && !is_find && rd_vld_reg && !expired;
        wr_en     = ins_wr || fl_wr;
        wr_addr   = ins_wr ? count_reg[IDX_W-1:0] : keep_reg[IDX_W-1:0];
        if (ins_wr)
        begin
            wr_data.src    = req_reg.src_addr;
            wr_data.dst    = req_reg.dst_addr;
            wr_data.id     = req_reg.message_id;
            wr_data.expiry = req_reg.expiry_time;
        end
        else
        begin
            wr_data = rd_data_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        keep_next  = keep_reg;
        rsp_next   = rsp_reg;

        if (ctl.load)
        begin
            ptr_next  = (req.opcode == OP_FIND) ? count_reg : '0;
            keep_next = '0;
        end
        if (rd_en)
        begin
            ptr_next = is_find ? ptr_dec : ptr_reg + 1'b1;
        end
        if (fl_wr)
        begin
            keep_next = keep_reg + 1'b1;
        end

        if (ctl.insert)
        begin
            rsp_next        = '0;
            rsp_next.status = full ? ST_FULL : ST_DONE;
            if (ins_wr)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (ctl.clear)
        begin
            rsp_next               = '0;
            rsp_next.status        = ST_DONE;
            rsp_next.removed_count = REMOVED_W'(count_reg);
            count_next             = '0;
        end

        if (ctl.scan && scan_end)
        begin
            rsp_next = '0;
            if (is_find)
            begin
                if (rd_vld_reg && match && !expired)
                begin
                    rsp_next.status       = ST_FOUND;
                    rsp_next.hit_dst_addr = rd_data_reg.dst;
                    rsp_next.hit_expiry   = rd_data_reg.expiry;
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            else
            begin
                rsp_next.status        = ST_DONE;
                rsp_next.removed_count = REMOVED_W'(count_reg - keep_reg);
                count_next             = keep_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            keep_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            keep_reg   <= keep_next;
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.scan_end = scan_end;
    assign rsp          = rsp_reg;

    `FDT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "entry count above depth")
    `FDT_ASSERT_IMP(a_rd_in_scan, rd_vld_reg, ctl.scan, "read data pending outside scan")
    `FDT_ASSERT_IMP(a_keep_trails, ctl.scan && !is_find, keep_reg <= ptr_reg, "compaction overtook read")

endmodule

/* sv/flood_duplicate_table_top.sv */
// Channel   Handshake                 Payload
// ------    ------------------------  -------------------------------
// request   start & !busy (accept)    req : fdt_req_t
// result    done, one-cycle strobe    rsp : fdt_rsp_t (no backpressure)
//
// Insert and clear: the result strobe follows the accept through the S_INS or S_CLR state and the done register.
// Find and flush walk the held entries; the table memory gives one entry
// per cycle through its registered read port.
// A new beat may be accepted in the same cycle as the result strobe.
// Reset clears the count, scan pointers and controller; table contents are not cleared.
// The receiver cannot stall: rsp is valid only while done is high.
module flood_duplicate_table_top
    import fdt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fdt_req_t req,
    output logic     busy,
    output logic     done,
    output fdt_rsp_t rsp
);

    fdt_ctl_t ctl;
    fdt_sts_t sts;

    fdt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .sts    (sts),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    fdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

/* sim/flood_duplicate_table_top_tb.sv */
`timescale 1ns / 1ps

module flood_duplicate_table_top_tb;
    import fdt_pkg::*;

    localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = DEPTH + 16;
    localparam int RANDOM_BEATS = 2000;
    localparam logic [31:0] ONES32 = '1;
    localparam logic [63:0] ONES64 = '1;

    typedef struct {
        fdt_req_t rq;
        bit       typed;
        fdt_rsp_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    fdt_req_t req   = '0;
    logic     busy;
    logic     done;
    fdt_rsp_t rsp;

    fdt_entry_t  shadow_tbl [DEPTH];
    int          shadow_fill;
    fdt_rsp_t    pending_rsp [$];
    dir_row_t    dir_rows [$];
    int          err_count;
    int          idle_cycles;
    int          burst_left;
    logic [63:0] sim_now;
    logic [31:0] src_pool [8];
    logic [31:0] id_pool [8];

    flood_duplicate_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // signed 64-bit view of (expiry - now); wraps safely
    function automatic bit entry_expired(logic [63:0] expiry, logic [63:0] now);
        logic [63:0] diff;
        diff = expiry - now;
        return diff[63];
    endfunction

    function automatic fdt_rsp_t apply_table_op(fdt_req_t r);
        fdt_rsp_t o;
        int       i;
        int       keep;
        o = '0;
        case (r.opcode)
            OP_INSERT:
            begin
                if (shadow_fill >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    shadow_tbl[shadow_fill].src    = r.src_addr;
                    shadow_tbl[shadow_fill].dst    = r.dst_addr;
                    shadow_tbl[shadow_fill].id     = r.message_id;
                    shadow_tbl[shadow_fill].expiry = r.expiry_time;
                    shadow_fill++;
                end
            end
            OP_FIND:
            begin
                o.status = ST_MISS;
                // newest first; everything behind an expired entry is older
                for (i = shadow_fill - 1; i >= 0; i--)
                begin
                    if (entry_expired(shadow_tbl[i].expiry, r.now_time))
                        break;
                    if (shadow_tbl[i].src == r.src_addr && shadow_tbl[i].id == r.message_id)
                    begin
                        o.status       = ST_FOUND;
                        o.hit_dst_addr = shadow_tbl[i].dst;
                        o.hit_expiry   = shadow_tbl[i].expiry;
                        break;
                    end
                end
            end
            OP_FLUSH:
            begin
                keep = 0;
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (entry_expired(shadow_tbl[i].expiry, r.now_time))
                        o.removed_count = o.removed_count + 1'b1;
                    else
                    begin
                        shadow_tbl[keep] = shadow_tbl[i];
                        keep++;
                    end
                end
                shadow_fill = keep;
            end
            default:
            begin
                o.removed_count = REMOVED_W'(shadow_fill);
                shadow_fill     = 0;
            end
        endcase
        return o;
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void check_result(fdt_rsp_t got);
        fdt_rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            note_error($sformatf("unexpected result beat: %h", got));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.hit_dst_addr !== want.hit_dst_addr
            || got.hit_expiry !== want.hit_expiry || got.removed_count !== want.removed_count)
            note_error($sformatf({"mismatch (exp/got): status %0d/%0d dst %h/%h ",
                                  "expiry %h/%h removed %0d/%0d"},
                                 want.status, got.status, want.hit_dst_addr, got.hit_dst_addr,
                                 want.hit_expiry, got.hit_expiry,
                                 want.removed_count, got.removed_count));
    endfunction

    task automatic step_clock(output bit accepted);
        @(posedge clk);
        accepted = start && !busy;
        if (done === 1'b1)
            check_result(rsp);
        if (accepted || done === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
    endtask

    task automatic send_beat(fdt_req_t r, bit typed, fdt_rsp_t want);
        bit       accepted;
        fdt_rsp_t predicted;
        req   <= r;
        start <= 1'b1;
        do
            step_clock(accepted);
        while (!accepted);
        predicted = apply_table_op(r);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic idle_for(int n);
        bit accepted;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) step_clock(accepted);
        end
    endtask

    task automatic drain_results();
        bit accepted;
        if (pending_rsp.size() != 0)
        begin
            start <= 1'b0;
            while (pending_rsp.size() != 0)
                step_clock(accepted);
        end
    endtask

    task automatic pace_sender();
        int gap;
        int roll;
        if (burst_left == 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
                gap = 0;
            else if (roll < 8)
                gap = $urandom_range(1, 6);
            else
                gap = $urandom_range(7, 45);
            idle_for(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    function automatic void add_row(fdt_op_t op, logic [31:0] src, logic [31:0] dst,
                                    logic [31:0] id, logic [63:0] expiry, logic [63:0] now,
                                    bit typed = 1'b0, fdt_status_t st = ST_DONE,
                                    logic [31:0] hit_dst = '0, logic [63:0] hit_exp = '0,
                                    logic [5:0] removed = '0);
        dir_row_t row;
        row.rq.opcode           = op;
        row.rq.src_addr         = src;
        row.rq.dst_addr         = dst;
        row.rq.message_id       = id;
        row.rq.expiry_time      = expiry;
        row.rq.now_time         = now;
        row.typed               = typed;
        row.want.status         = st;
        row.want.hit_dst_addr   = hit_dst;
        row.want.hit_expiry     = hit_exp;
        row.want.removed_count  = removed;
        dir_rows.push_back(row);
    endfunction

    // Random traffic follows a moving clock: inserts live a short while past now,
    // finds mostly ask for keys that are held, flushes use the same now.
    function automatic fdt_req_t next_random_beat(int mix);
        fdt_req_t r;
        int       roll;
        int       pick;
        int       ins_cut;
        int       find_cut;
        int       flush_cut;
        r.opcode      = fdt_op_t'($urandom_range(0, 3));
        r.src_addr    = $urandom;
        r.dst_addr    = $urandom;
        r.message_id  = $urandom;
        r.expiry_time = {$urandom, $urandom};
        r.now_time    = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 8)
            return r;

        sim_now += $urandom_range(0, 8);
        if ($urandom_range(0, 299) == 0)
            sim_now = {$urandom, $urandom};
        if ($urandom_range(0, 99) == 0)
            src_pool[$urandom_range(0, 7)] = $urandom;
        if ($urandom_range(0, 99) == 0)
            id_pool[$urandom_range(0, 7)] = $urandom;

        case (mix)
            0:       begin ins_cut = 80; find_cut = 95; flush_cut = 98; end
            1:       begin ins_cut = 40; find_cut = 85; flush_cut = 95; end
            default: begin ins_cut = 20; find_cut = 90; flush_cut = 98; end
        endcase

        roll = $urandom_range(0, 99);
        if (roll < ins_cut)
        begin
            r.opcode     = OP_INSERT;
            r.src_addr   = src_pool[$urandom_range(0, 7)];
            r.message_id = id_pool[$urandom_range(0, 7)];
            roll = $urandom_range(0, 99);
            if (roll < 10)
                r.expiry_time = sim_now - $urandom_range(1, 30);
            else if (roll >= 15)
                r.expiry_time = sim_now + $urandom_range(0, 140);
        end
        else if (roll < find_cut)
        begin
            r.opcode   = OP_FIND;
            r.now_time = sim_now;
            if (shadow_fill > 0 && $urandom_range(0, 99) < 70)
            begin
                pick         = $urandom_range(0, shadow_fill - 1);
                r.src_addr   = shadow_tbl[pick].src;
                r.message_id = shadow_tbl[pick].id;
                if ($urandom_range(0, 9) == 0)
                    r.message_id[$urandom_range(0, 31)] ^= 1'b1;
            end
            else
            begin
                r.src_addr   = src_pool[$urandom_range(0, 7)];
                r.message_id = id_pool[$urandom_range(0, 7)];
            end
        end
        else if (roll < flush_cut)
        begin
            r.opcode   = OP_FLUSH;
            r.now_time = sim_now;
        end
        else
            r.opcode = OP_CLEAR;
        return r;
    endfunction

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int  beats;
        int  phase_end;
        bit  accepted;

        err_count   = 0;
        idle_cycles = 0;
        burst_left  = 0;
        shadow_fill = 0;
        sim_now     = {$urandom, $urandom};
        for (int k = 0; k < 8; k++)
        begin
            src_pool[k] = $urandom;
            id_pool[k]  = $urandom;
        end

        // empty table right after reset
        add_row(OP_FIND,   0, 0, 0, 0, 0, 1'b1, ST_MISS);
        add_row(OP_FLUSH,  ONES32, ONES32, ONES32, ONES64, ONES64, 1'b1, ST_DONE);
        add_row(OP_CLEAR,  ONES32, ONES32, ONES32, ONES64, ONES64, 1'b1, ST_DONE);
        // field extremes; unused fields carry the opposite extreme
        add_row(OP_INSERT, 0, 0, 0, 0, ONES64, 1'b1, ST_DONE);
        add_row(OP_INSERT, ONES32, ONES32, ONES32, ONES64, 0, 1'b1, ST_DONE);
        add_row(OP_FIND,   ONES32, 0, ONES32, 0, ONES64 - 1, 1'b1, ST_FOUND,
                ONES32, ONES64);
        add_row(OP_FIND,   0, ONES32, 0, ONES64, ONES64 - 1);
        // newest entry expired: scan stops before the older match
        add_row(OP_FIND,   0, 0, 0, 0, 64'd1);
        // same key twice, the newer one must win
        add_row(OP_INSERT, 32'h0A00_0001, 32'h0A00_00FE, 32'd7, 64'd100, 0, 1'b1, ST_DONE);
        add_row(OP_INSERT, 32'h0A00_0001, 32'h0A00_00FF, 32'd7, 64'd200, 0, 1'b1, ST_DONE);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd7, 0, 64'd100);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd7, 0, 64'd200);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd7, 0, 64'd201);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd8, 0, 64'd0);
        // expiry just past the wrap of now
        add_row(OP_INSERT, 32'd5, 32'd6, 32'd5, 64'd5, 0, 1'b1, ST_DONE);
        add_row(OP_FIND,   32'd5, 0, 32'd5, 0, 64'hFFFF_FFFF_FFFF_FFFB);
        // drops the two oldest, keeps order of the rest
        add_row(OP_FLUSH,  0, 0, 0, 0, 64'd3);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd7, 0, 64'd3);
        // difference of exactly half the range reads negative
        add_row(OP_INSERT, 32'd9, 32'd9, 32'd9, 64'h8000_0000_0000_0000, 0, 1'b1, ST_DONE);
        add_row(OP_FIND,   32'd9, 0, 32'd9, 0, 64'd0);
        add_row(OP_FLUSH,  0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        add_row(OP_CLEAR,  0, 0, 0, 0, 0);
        add_row(OP_FIND,   32'h0A00_0001, 0, 32'd7, 0, 64'd3, 1'b1, ST_MISS);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) step_clock(accepted);

        foreach (dir_rows[k])
        begin
            pace_sender();
            send_beat(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);
        end
        drain_results();

        // phases of differing op mix, each ending with the sender held off
        beats = 0;
        while (beats < RANDOM_BEATS)
        begin
            phase_end = beats + $urandom_range(40, 220);
            begin
                int mix;
                mix = $urandom_range(0, 2);
                while (beats < phase_end && beats < RANDOM_BEATS)
                begin
                    pace_sender();
                    send_beat(next_random_beat(mix), 1'b0, '0);
                    beats++;
                end
            end
            drain_results();
        end

        // catch any stray result beats
        idle_for(TAIL_CYCLES);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
